FILE: hw/rtl/srmp_pkg.sv
// shared types and constants for the segmented row max pooling block
// no dependencies; used by the top level and its checker
`timescale 1ns / 1ps

package srmp_pkg;

  localparam int MaxColumns = 1024;
  localparam int ColW       = $clog2(MaxColumns);
  localparam int WidthW     = $clog2(MaxColumns) + 1;
  localparam int ValueW     = 32;
  localparam int DataW      = 32;
  localparam int CfgAddrW   = 3;

  localparam logic [WidthW-1:0] RowWidthReset = WidthW'(768);

  typedef logic signed [ValueW-1:0] sample_t;
  typedef logic [ColW-1:0]          col_t;
  typedef logic [WidthW-1:0]        width_t;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_ROW_WIDTH = 1'b0
  } cfg_reg_t;

endpackage

FILE: hw/rtl/segmented_row_max_pooling.sv
// Segmented row max pooling: one element per cycle unless the output stalls, one output per last-row element
// Depends on srmp_pkg for widths, types and register indexes
`timescale 1ns / 1ps

// Streams token vectors element by element in row-major order and keeps a running
// signed maximum per hidden column in a 1024 x 32 memory. A first-row element loads
// its column, later rows keep the larger value, and a last-row element emits the
// column maximum with its column index, row_done marking the final column. The block
// accepts one item every cycle unless a held result stalls the compare stage. Each
// item makes one read-modify-write pass on the column memory: a registered read in
// the accept cycle, compare and write back in the compare stage, with a one-entry
// forwarding register for back-to-back hits on the same column. The memory is not
// cleared at reset; a column must be loaded by a first-row element before a later
// row reads it. row_width (address 0) is clamped to 1..1024 and changes neither
// the stored maxima nor the column counter.
module segmented_row_max_pooling (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [srmp_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [srmp_pkg::DataW-1:0]    cfg_pwdata,
  output logic [srmp_pkg::DataW-1:0]    cfg_prdata,
  output logic                          cfg_pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [srmp_pkg::ValueW-1:0] in_sample_value,
  input  logic                          in_first_row,
  input  logic                          in_last_row,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [srmp_pkg::ValueW-1:0] out_pooled_value,
  output logic [srmp_pkg::ColW-1:0]     out_column_index,
  output logic                          out_row_done
);

  // configuration
  srmp_pkg::width_t row_width_r;
  srmp_pkg::width_t eff_width;
  logic             cfg_wr;

  // accept stage
  srmp_pkg::col_t   col_cnt_r, col_cnt_nxt;
  srmp_pkg::col_t   cur_col;
  logic             cur_final;
  logic             in_fire;

  // compare stage
  logic             s1_valid_r;
  srmp_pkg::sample_t s1_value_r;
  logic             s1_first_r, s1_last_r, s1_final_r;
  srmp_pkg::col_t   s1_col_r;
  logic             s1_adv;
  srmp_pkg::sample_t mem_rd_r;
  srmp_pkg::sample_t old_max, new_max;

  // last write back, forwarded to the next read of the same column
  logic             wb_valid_r;
  srmp_pkg::col_t   wb_col_r;
  srmp_pkg::sample_t wb_value_r;

  // output register
  logic             out_valid_r;
  srmp_pkg::sample_t out_value_r;
  srmp_pkg::col_t   out_col_r;
  logic             out_done_r;

  logic [srmp_pkg::ValueW-1:0] col_mem [srmp_pkg::MaxColumns];

  // apb access
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == srmp_pkg::REG_ROW_WIDTH);

  always_comb begin
    case (cfg_paddr[2])
      srmp_pkg::REG_ROW_WIDTH: cfg_prdata = srmp_pkg::DataW'(row_width_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= srmp_pkg::RowWidthReset;
    end else if (cfg_wr) begin
      row_width_r <= cfg_pwdata[srmp_pkg::WidthW-1:0];
    end
  end

  always_comb begin
    if (row_width_r == '0) begin
      eff_width = srmp_pkg::WidthW'(1);
    end else if (row_width_r > srmp_pkg::WidthW'(srmp_pkg::MaxColumns)) begin
      eff_width = srmp_pkg::WidthW'(srmp_pkg::MaxColumns);
    end else begin
      eff_width = row_width_r;
    end
  end

  // column of the incoming item; a counter left past a narrowed width restarts at 0
  always_comb begin
    if ({1'b0, col_cnt_r} >= eff_width) begin
      cur_col = '0;
    end else begin
      cur_col = col_cnt_r;
    end
    cur_final   = ({1'b0, cur_col} == (eff_width - srmp_pkg::WidthW'(1)));
    col_cnt_nxt = cur_final ? '0 : cur_col + srmp_pkg::ColW'(1);
  end

  // compare stage moves on unless it holds a result and the output is blocked
  assign s1_adv   = !s1_last_r || !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    if (wb_valid_r && (wb_col_r == s1_col_r)) begin
      old_max = wb_value_r;
    end else begin
      old_max = mem_rd_r;
    end
    if (s1_first_r || (s1_value_r > old_max)) begin
      new_max = s1_value_r;
    end else begin
      new_max = old_max;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      wb_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        col_cnt_r <= col_cnt_nxt;
      end
      if (in_ready) begin
        s1_valid_r <= in_fire;
      end
      if (s1_valid_r && s1_adv) begin
        wb_valid_r <= 1'b1;
      end
      if (s1_valid_r && s1_adv && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_value_r <= in_sample_value;
      s1_first_r <= in_first_row;
      s1_last_r  <= in_last_row;
      s1_col_r   <= cur_col;
      s1_final_r <= cur_final;
    end
    if (s1_valid_r && s1_adv) begin
      wb_col_r   <= s1_col_r;
      wb_value_r <= new_max;
    end
    if (s1_valid_r && s1_adv && s1_last_r) begin
      out_value_r <= new_max;
      out_col_r   <= s1_col_r;
      out_done_r  <= s1_final_r;
    end
  end

  // column memory: read in the accept cycle, write back from the compare stage
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem_rd_r <= col_mem[cur_col];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      col_mem[s1_col_r] <= new_max;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pooled_value = out_value_r;
  assign out_column_index = out_col_r;
  assign out_row_done     = out_done_r;

endmodule

FILE: hw/rtl/srmp_checker.sv
// Port-level checks for segmented_row_max_pooling, bound to the top level
// Depends on srmp_pkg and the top level's port list
`timescale 1ns / 1ps

module srmp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_last_row,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [srmp_pkg::ValueW-1:0] out_pooled_value,
  input logic [srmp_pkg::ColW-1:0]     out_column_index,
  input logic                          out_row_done
);

  // a waiting result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  // a waiting result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pooled_value) && $stable(out_column_index)
      && $stable(out_row_done))
    else $error("result changed while stalled");

  // with the output register empty nothing can block the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a last-row item taken into an idle output yields a result after the compare stage
  a_result_due: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_row && !out_valid |-> ##2 out_valid)
    else $error("result missing after last-row item");

endmodule

bind segmented_row_max_pooling srmp_checker u_srmp_checker (.*);

FILE: tb/tb.sv
// self-checking testbench for segmented_row_max_pooling: directed and random items
// depends on srmp_pkg and the block's RTL; keeps its own column-max model for checking
`timescale 1ns / 1ps

module tb;
  import srmp_pkg::*;

  localparam logic [CfgAddrW-1:0] RowWidthAddr = {REG_ROW_WIDTH, 2'b00};
  // no register decodes here
  localparam logic [CfgAddrW-1:0] SpareAddr    = 3'b100;
  localparam sample_t MostPositive = 32'sh7FFF_FFFF;
  localparam sample_t MostNegative = 32'sh8000_0000;

  typedef struct {
    sample_t value;
    col_t    column;
    logic    done;
  } pooled_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CfgAddrW-1:0] cfg_paddr;
  logic [DataW-1:0]    cfg_pwdata;
  logic [DataW-1:0]    cfg_prdata;
  logic                cfg_pready;
  logic                in_valid;
  logic                in_ready;
  sample_t             in_sample_value;
  logic                in_first_row;
  logic                in_last_row;
  logic                out_valid;
  logic                out_ready = 1'b0;
  sample_t             out_pooled_value;
  col_t                out_column_index;
  logic                out_row_done;

  // model of the block
  sample_t col_max [MaxColumns];
  bit      col_loaded [MaxColumns];
  col_t    col_next;
  width_t  width_reg;
  pooled_t pooled_expect [$];

  int unsigned items_sent;
  int unsigned error_count;
  bit          steady_in;
  bit          steady_out;

  segmented_row_max_pooling DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_value  (in_sample_value),
    .in_first_row     (in_first_row),
    .in_last_row      (in_last_row),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pooled_value (out_pooled_value),
    .out_column_index (out_column_index),
    .out_row_done     (out_row_done)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MaxColumns) return MaxColumns;
    return width_reg;
  endfunction

  // a counter left past the width by a config write restarts at column 0
  function automatic col_t entry_col();
    return (col_next >= active_width()) ? '0 : col_next;
  endfunction

  function automatic void pool_sample(sample_t v, logic f, logic l);
    col_t    c;
    logic    last_col;
    pooled_t r;
    c = entry_col();
    if (f || v > col_max[c]) col_max[c] = v;
    if (f) col_loaded[c] = 1'b1;
    last_col = (c == active_width() - 1);
    col_next = last_col ? '0 : c + 1'b1;
    if (l) begin
      r.value  = col_max[c];
      r.column = c;
      r.done   = last_col;
      pooled_expect.insert(pooled_expect.size(), r);
    end
  endfunction

  function automatic sample_t pick_value();
    case ($urandom_range(7))
      0: return MostPositive;
      1: return MostNegative;
      2: return '0;
      3: return -1;
      4: return sample_t'($signed($urandom_range(200)) - 100);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $time, what);
    error_count++;
  endtask

  // entered and left at a falling edge
  task automatic send_sample(sample_t v, logic f, logic l);
    while (!steady_in && $urandom_range(99) < 14) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    // a column no first row has loaded yet must open a segment
    if (!col_loaded[entry_col()]) f = 1'b1;
    in_valid        = 1'b1;
    in_sample_value = v;
    in_first_row    = f;
    in_last_row     = l;
    do @(posedge clk); while (!in_ready);
    pool_sample(v, f, l);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_noise(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_sample(pick_value(), $urandom_range(99) < 30, $urandom_range(99) < 40);
  endtask

  task automatic send_segment(int unsigned rows);
    int unsigned w;
    w = active_width();
    // finish a partial row so the segment starts on column 0
    while (entry_col() != 0) send_noise(1);
    for (int unsigned r = 0; r < rows; r++)
      for (int unsigned c = 0; c < w; c++)
        send_sample(pick_value(), r == 0, r == rows - 1);
  endtask

  task automatic wait_for_results();
    in_valid = 1'b0;
    while (pooled_expect.size() != 0) @(posedge clk);
    // an item without last_row may still be in the pipe
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_access(logic wr, logic [CfgAddrW-1:0] addr, logic [DataW-1:0] data);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = wr;
    cfg_paddr   = addr;
    cfg_pwdata  = wr ? data : '0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (!wr && cfg_prdata !== data)
      report_mismatch($sformatf("read addr %0d got %0h want %0h", addr, cfg_prdata, data));
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic set_row_width(int unsigned w);
    wait_for_results();
    apb_access(1'b1, RowWidthAddr, DataW'(w));
    width_reg = width_t'(w);
    apb_access(1'b0, RowWidthAddr, DataW'(width_reg));
  endtask

  task automatic test_directed();
    // reset width, one-row segments with the value extremes
    send_sample(MostPositive, 1'b1, 1'b1);
    send_sample(MostNegative, 1'b1, 1'b1);
    send_sample('0, 1'b1, 1'b1);
    send_sample(-1, 1'b1, 1'b1);
    send_sample(1, 1'b1, 1'b1);
    // counter sits at 5, past the new width
    set_row_width(3);
    // two rows: ties, sign crossings, extremes
    send_sample(-5, 1'b1, 1'b0);
    send_sample(MostNegative, 1'b1, 1'b0);
    send_sample(7, 1'b1, 1'b0);
    send_sample(-5, 1'b0, 1'b1);
    send_sample(MostPositive, 1'b0, 1'b1);
    send_sample(-7, 1'b0, 1'b1);
    // flags change within a row
    send_sample(10, 1'b1, 1'b1);
    send_sample(MostNegative, 1'b1, 1'b0);
    send_sample(3, 1'b0, 1'b0);
    send_sample(20, 1'b0, 1'b1);
    send_sample(MostNegative, 1'b0, 1'b1);
    send_sample(2, 1'b0, 1'b1);
    // three rows, middle row with no flag
    send_sample(MostNegative, 1'b1, 1'b0);
    send_sample(0, 1'b1, 1'b0);
    send_sample(MostPositive, 1'b1, 1'b0);
    send_sample(-1, 1'b0, 1'b0);
    send_sample(MostPositive, 1'b0, 1'b0);
    send_sample(1, 1'b0, 1'b0);
    send_sample(-2, 1'b0, 1'b1);
    send_sample(-1, 1'b0, 1'b1);
    send_sample(MostNegative, 1'b0, 1'b1);
  endtask

  task automatic test_width_limits();
    // writes to an unused address leave the register alone
    wait_for_results();
    apb_access(1'b1, SpareAddr, $urandom);
    apb_access(1'b0, RowWidthAddr, DataW'(width_reg));
    // zero acts as one column
    set_row_width(0);
    send_noise(6);
    set_row_width(1);
    send_noise(6);
    set_row_width(MaxColumns);
    for (int unsigned c = 0; c < 8; c++) send_sample(pick_value(), 1'b1, 1'b1);
    // all ones clamps to the full width
    set_row_width('1);
    for (int unsigned c = 0; c < 8; c++) send_sample(pick_value(), 1'b0, 1'b1);
  endtask

  task automatic send_mix(int unsigned n);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < n) begin
      if ($urandom_range(99) < 75) send_segment($urandom_range(1, 4));
      else send_noise($urandom_range(1, 12));
    end
  endtask

  task automatic test_random_segments();
    int unsigned start;
    int unsigned phase;
    start = items_sent;
    phase = 0;
    while (items_sent - start < 620) begin
      case ($urandom_range(5))
        0: set_row_width(1);
        1: set_row_width(2);
        2: set_row_width($urandom_range(3, 8));
        3: set_row_width($urandom_range(9, 40));
        4: set_row_width(0);
        default: set_row_width($urandom_range(1, 16));
      endcase
      // one phase runs without any idling on either side
      steady_in  = (phase == 2);
      steady_out = (phase == 2);
      send_mix(50);
      if (phase == 1 || $urandom_range(1)) wait_for_results();
      send_mix(50);
      phase++;
    end
    steady_in  = 1'b0;
    steady_out = 1'b0;
  endtask

  always @(negedge clk) out_ready = steady_out || ($urandom_range(99) >= 14);

  always @(posedge clk) begin : check_pooled
    pooled_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pooled_expect.size() == 0) begin
        report_mismatch($sformatf("unexpected item value %0d col %0d",
                                  out_pooled_value, out_column_index));
      end else begin
        want = pooled_expect.pop_front();
        if (out_pooled_value !== want.value)
          report_mismatch($sformatf("col %0d value %0d want %0d",
                                    want.column, out_pooled_value, want.value));
        if (out_column_index !== want.column)
          report_mismatch($sformatf("column %0d want %0d", out_column_index, want.column));
        if (out_row_done !== want.done)
          report_mismatch($sformatf("col %0d row_done %0b want %0b",
                                    want.column, out_row_done, want.done));
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    in_valid        = 1'b0;
    in_sample_value = '0;
    in_first_row    = 1'b0;
    in_last_row     = 1'b0;
    width_reg       = RowWidthReset;
    col_next        = '0;
    items_sent      = 0;
    error_count     = 0;
    steady_in       = 1'b0;
    steady_out      = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_width_limits();
    test_random_segments();

    in_valid = 1'b0;
    while (pooled_expect.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
